@@ design/bitplane_raster_draw_engine_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Raster draw engine assertion macros
// Shared assertion forms used by the draw engine modules.
// ---------------------------------------------------------------------------
`ifndef BITPLANE_RASTER_DRAW_ENGINE_UNIT_DEFINES_SVH
`define BITPLANE_RASTER_DRAW_ENGINE_UNIT_DEFINES_SVH

// Asserts that an implication holds on every clock edge outside reset.
`define BRD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Asserts that a condition implies another condition in the next cycle.
`define BRD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ design/brd_pkg.sv @@
// ---------------------------------------------------------------------------
// Raster draw engine package
// Command codes, raster op codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`default_nettype none
package brd_pkg;
	localparam logic [2:0] CMD_SET   = 3'd0;
	localparam logic [2:0] CMD_READ  = 3'd1;
	localparam logic [2:0] CMD_HSPAN = 3'd2;
	localparam logic [2:0] CMD_VSPAN = 3'd3;
	localparam logic [2:0] CMD_LINE  = 3'd4;
	localparam logic [2:0] CMD_CLEAR = 3'd5;

	localparam logic [2:0] OP_SET = 3'd0;
	localparam logic [2:0] OP_OR  = 3'd1;
	localparam logic [2:0] OP_INV = 3'd2;
	localparam logic [2:0] OP_AND = 3'd3;
	localparam logic [2:0] OP_XOR = 3'd4;

	localparam logic [7:0] LEFT_BIT = 8'h80;
	localparam logic [7:0] ALL_ONES = 8'hFF;

	// Command from controller to datapath for one pixel or byte access.
	typedef struct packed {
		logic       rd;      // issue a store read of the pixel byte
		logic       wr;      // write the modified byte back
		logic       clr;     // write zero to clear address
		logic       cap;     // capture read colour into output
		logic       clr_rd;  // zero the read colour before a pixel read
	} brd_cmd_t;
endpackage
`default_nettype wire

@@ design/brd_datapath.sv @@
// ---------------------------------------------------------------------------
// Raster draw engine datapath
// Frame store memory, address generation and the raster op on one byte.
// ---------------------------------------------------------------------------
`default_nettype none
module brd_datapath
	import brd_pkg::*;
#(
	parameter int ROW_BYTES   = 24,
	parameter int SCREEN_ROWS = 64,
	parameter int PLANES      = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire brd_cmd_t   cmd,
	input  wire logic [7:0] px,
	input  wire logic [7:0] py,
	input  wire logic [$clog2(PLANES+1)-1:0] plane,
	input  wire logic [$clog2(ROW_BYTES*SCREEN_ROWS*PLANES)-1:0] clr_addr,
	input  wire logic [1:0] color,
	input  wire logic [2:0] rop,
	output logic [1:0]      rd_color
);
	localparam int DEPTH = ROW_BYTES * SCREEN_ROWS * PLANES;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = $clog2(PLANES + 1);

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rdata_q;
	logic [AW-1:0] addr;
	logic [AW-1:0] addr_q;
	logic [7:0]    mask_q;
	logic          cbit_q;
	logic [PW-1:0] plane_q;
	logic [7:0]    mask;
	logic [7:0]    wdata;
	logic          cbit;

	// Byte address and bit mask of the pixel in the selected plane.
	always_comb begin
		addr = AW'(32'(plane) * ROW_BYTES * SCREEN_ROWS + 32'(py) * ROW_BYTES
			+ 32'(px[7:3]));
		mask = LEFT_BIT >> px[2:0];
		cbit = (32'(plane) < 2) ? color[plane[0]] : 1'b0;
	end

	// Raster op applied to the byte captured by the previous store read.
	always_comb begin
		case (rop)
			OP_SET:  wdata = cbit_q ? (rdata_q | mask_q) : (rdata_q & ~mask_q);
			OP_OR:   wdata = cbit_q ? (rdata_q | mask_q) : rdata_q;
			OP_INV:  wdata = cbit_q ? (rdata_q & ~mask_q) : (rdata_q | mask_q);
			OP_AND:  wdata = cbit_q ? rdata_q : (rdata_q & ~mask_q);
			OP_XOR:  wdata = cbit_q ? (rdata_q ^ mask_q) : rdata_q;
			default: wdata = rdata_q & ALL_ONES;
		endcase
	end

	// Store port: one read or one write per cycle.
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			mem[clr_addr] <= 8'd0;
		end else if (cmd.wr) begin
			mem[addr_q] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[addr];
			addr_q  <= addr;
			mask_q  <= mask;
			cbit_q  <= cbit;
			plane_q <= plane;
		end
	end

	// Read colour collection, one plane at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_color <= 2'd0;
		end else if (cmd.clr || cmd.clr_rd) begin
			rd_color <= 2'd0;
		end else if (cmd.cap && 32'(plane_q) < 2) begin
			rd_color[plane_q[0]] <= |(rdata_q & mask_q);
		end
	end
endmodule
`default_nettype wire

@@ design/brd_ctrl.sv @@
// ---------------------------------------------------------------------------
// Raster draw engine controller
// Walks pixels of each command and sequences per-plane read-modify-writes.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bitplane_raster_draw_engine_unit_defines.svh"
module brd_ctrl
	import brd_pkg::*;
#(
	parameter int ROW_BYTES   = 24,
	parameter int SCREEN_ROWS = 64,
	parameter int PLANES      = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] in_cmd,
	input  wire logic [7:0] in_xs,
	input  wire logic [7:0] in_ys,
	input  wire logic [7:0] in_xe,
	input  wire logic [7:0] in_ye,
	input  wire logic [1:0] in_color,
	input  wire logic [2:0] in_rop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output brd_cmd_t        cmd,
	output logic [7:0]      px,
	output logic [7:0]      py,
	output logic [$clog2(PLANES+1)-1:0] plane,
	output logic [$clog2(ROW_BYTES*SCREEN_ROWS*PLANES)-1:0] clr_addr,
	output logic [1:0]      color,
	output logic [2:0]      rop
);
	localparam int DEPTH = ROW_BYTES * SCREEN_ROWS * PLANES;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = $clog2(PLANES + 1);
	localparam int COLS  = ROW_BYTES * 8;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CLEAR, ST_PIX, ST_RD, ST_WR, ST_NEXT, ST_OUT
	} state_t;

	state_t        state_q;
	logic [2:0]    kind_q;
	logic [8:0]    cx_q, cy_q, end_q;
	logic signed [10:0] err_q, dx_q, dy_q;
	logic          steep_q, up_q, read_q;
	logic [PW-1:0] plane_q;
	logic [AW-1:0] caddr_q;
	logic [7:0]    px_q, py_q;
	logic [1:0]    color_q;
	logic [2:0]    rop_q;
	logic          onscr;
	logic signed [10:0] err_n;
	logic [8:0]    lo, hi;

	assign px    = px_q;
	assign py    = py_q;
	assign plane = plane_q;
	assign clr_addr = caddr_q;
	assign color = color_q;
	assign rop   = rop_q;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign onscr = (32'(px_q) < COLS) && (32'(py_q) < SCREEN_ROWS);
	assign err_n = err_q + 11'(2 * dy_q);

	// Store commands for the current state.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: cmd.clr = 1'b1;
			ST_PIX:   cmd.clr_rd = read_q;
			ST_RD:    cmd.rd  = 1'b1;
			ST_WR: begin
				cmd.wr  = !read_q && (rop_q <= OP_XOR);
				cmd.cap = read_q;
			end
			default: cmd = '0;
		endcase
	end

	// Setup of the walk coordinates for the accepted command.
	always_comb begin
		lo = 9'(in_xs);
		hi = 9'(in_xe);
		if (in_cmd == CMD_VSPAN) begin
			lo = (in_ys < in_ye) ? 9'(in_ys) : 9'(in_ye);
			hi = (in_ys < in_ye) ? 9'(in_ye) : 9'(in_ys);
		end else if (in_cmd == CMD_HSPAN) begin
			lo = (in_xs < in_xe) ? 9'(in_xs) : 9'(in_xe);
			hi = (in_xs < in_xe) ? 9'(in_xe) : 9'(in_xs);
		end
	end

	// Line setup: normalized so the major axis walks upward.
	logic signed [10:0] ldx, ldy, adx, ady;
	logic [7:0] lx0, ly0, lx1, ly1;
	always_comb begin
		if (in_xe < in_xs) begin
			lx0 = in_xe; ly0 = in_ye; lx1 = in_xs; ly1 = in_ys;
		end else begin
			lx0 = in_xs; ly0 = in_ys; lx1 = in_xe; ly1 = in_ye;
		end
		ldx = 11'(lx1) - 11'(lx0);
		ldy = 11'(ly1) - 11'(ly0);
		adx = ldx;
		ady = (ldy < 0) ? -ldy : ldy;
	end

	// State machine and walk registers; reset starts with a sweep that zeros the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			kind_q  <= '0;
			cx_q <= '0; cy_q <= '0; end_q <= '0;
			err_q <= '0; dx_q <= '0; dy_q <= '0;
			steep_q <= 1'b0; up_q <= 1'b0; read_q <= 1'b0;
			plane_q <= '0; caddr_q <= '0;
			px_q <= '0; py_q <= '0; color_q <= '0; rop_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					kind_q  <= in_cmd;
					color_q <= in_color;
					rop_q   <= (in_cmd == CMD_HSPAN || in_cmd == CMD_VSPAN) ? in_rop : OP_SET;
					read_q  <= (in_cmd == CMD_READ);
					caddr_q <= '0;
					steep_q <= 1'b0;
					up_q    <= 1'b1;
					err_q   <= '0;
					dx_q    <= '0;
					dy_q    <= '0;
					unique case (in_cmd)
						CMD_SET, CMD_READ: begin
							cx_q <= 9'(in_xs); cy_q <= 9'(in_ys); end_q <= 9'(in_xs);
							state_q <= ST_PIX;
						end
						CMD_HSPAN: begin
							cx_q <= lo; cy_q <= 9'(in_ys); end_q <= hi;
							state_q <= ST_PIX;
						end
						CMD_VSPAN: begin
							cx_q <= lo; cy_q <= 9'(in_xs); end_q <= hi;
							steep_q <= 1'b1;
							state_q <= ST_PIX;
						end
						CMD_LINE: begin
							up_q <= !(ldy < 0);
							if (ldy == 0 || ldx == 0 || ady <= adx) begin
								if (ldx == 0) begin
									steep_q <= 1'b1;
									cx_q <= (in_ys < in_ye) ? 9'(in_ys) : 9'(in_ye);
									end_q <= (in_ys < in_ye) ? 9'(in_ye) : 9'(in_ys);
									cy_q <= 9'(lx0);
								end else begin
									cx_q <= 9'(lx0); end_q <= 9'(lx1); cy_q <= 9'(ly0);
									dx_q <= adx; dy_q <= (ldy == 0) ? 11'sd0 : ady;
									err_q <= -adx;
								end
							end else begin
								// Steep line: walk y, lower y first.
								steep_q <= 1'b1;
								dx_q <= ady; dy_q <= adx; err_q <= -ady;
								if (ldy < 0) begin
									cx_q <= 9'(ly1); end_q <= 9'(ly0); cy_q <= 9'(lx1);
								end else begin
									cx_q <= 9'(ly0); end_q <= 9'(ly1); cy_q <= 9'(lx0);
								end
							end
							state_q <= ST_PIX;
						end
						CMD_CLEAR: state_q <= ST_CLEAR;
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_CLEAR: begin
					caddr_q <= caddr_q + AW'(1);
					if (32'(caddr_q) == DEPTH - 1) state_q <= ST_IDLE;
				end
				ST_PIX: begin
					px_q <= steep_q ? cy_q[7:0] : cx_q[7:0];
					py_q <= steep_q ? cx_q[7:0] : cy_q[7:0];
					plane_q <= '0;
					state_q <= ST_RD;
				end
				ST_RD: state_q <= onscr ? ST_WR : ST_NEXT;
				ST_WR: begin
					if (32'(plane_q) == PLANES - 1) begin
						state_q <= ST_NEXT;
					end else begin
						plane_q <= plane_q + PW'(1);
						state_q <= ST_RD;
					end
				end
				ST_NEXT: begin
					if (read_q) begin
						state_q <= ST_OUT;
					end else if (cx_q >= end_q) begin
						state_q <= ST_IDLE;
					end else begin
						cx_q <= cx_q + 9'd1;
						if (kind_q == CMD_LINE && dy_q != 0) begin
							if (err_n > 0) begin
								cy_q  <= up_q ? cy_q + 9'd1 : cy_q - 9'd1;
								err_q <= err_n - 11'(2 * dx_q);
							end else begin
								err_q <= err_n;
							end
						end
						state_q <= ST_PIX;
					end
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`BRD_ASSERT_IMP(a_ready_idle, in_ready, !out_valid)
	`BRD_ASSERT_IMP(a_one_access, cmd.rd, !cmd.wr && !cmd.clr)
	`BRD_ASSERT_NEXT(a_rd_then_wr, state_q == ST_RD && onscr, state_q == ST_WR)
endmodule
`default_nettype wire

@@ design/bitplane_raster_draw_engine_unit.sv @@
// ---------------------------------------------------------------------------
// Bitplane raster draw engine
// Pixel, span, line and clear operations on a bitplane frame store.
// ---------------------------------------------------------------------------
// One command is taken at a time. Each on-screen pixel runs a setup state, a
// read state and a write state per plane on the single store port (the write
// state writes back only for a draw with a valid raster op; a read captures
// the colour there instead) and a step state; an off-screen pixel has only
// its setup, one read and its step. A read pixel presents its colour after
// its step state (zero when off screen). A clear sweeps the store at one byte
// per cycle. The same sweep runs once after reset, so the input is not ready
// until it ends; store contents then read as zero.
`default_nettype none
module bitplane_raster_draw_engine_unit
	import brd_pkg::*;
#(
	parameter int ROW_BYTES   = 24,
	parameter int SCREEN_ROWS = 64,
	parameter int PLANES      = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// command[2:0], x_start[10:3], y_start[18:11], x_end[26:19],
	// y_end[34:27], color[36:35], raster_op[39:37]
	input  wire logic [39:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// pixel_color[1:0]
	output logic [7:0]       m_axis_tdata
);
	brd_cmd_t   cmd;
	logic [7:0] px, py;
	logic [$clog2(PLANES+1)-1:0] plane;
	logic [$clog2(ROW_BYTES*SCREEN_ROWS*PLANES)-1:0] clr_addr;
	logic [1:0] color, rd_color;
	logic [2:0] rop;

	assign m_axis_tdata = {6'd0, rd_color};

	brd_ctrl #(.ROW_BYTES(ROW_BYTES), .SCREEN_ROWS(SCREEN_ROWS), .PLANES(PLANES)) u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_cmd(s_axis_tdata[2:0]), .in_xs(s_axis_tdata[10:3]),
		.in_ys(s_axis_tdata[18:11]), .in_xe(s_axis_tdata[26:19]),
		.in_ye(s_axis_tdata[34:27]), .in_color(s_axis_tdata[36:35]),
		.in_rop(s_axis_tdata[39:37]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.cmd, .px, .py, .plane, .clr_addr, .color, .rop
	);

	brd_datapath #(.ROW_BYTES(ROW_BYTES), .SCREEN_ROWS(SCREEN_ROWS), .PLANES(PLANES)) u_dp (
		.clk, .arst_n, .cmd, .px, .py, .plane, .clr_addr, .color, .rop, .rd_color
	);
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// Bitplane raster draw engine testbench
// Sends draw commands over the input stream and compares every colour read
// back on the output stream with a local frame store model or a colour typed
// into the table. A short directed table comes first, then a long random run.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import brd_pkg::*;

	localparam int ROW_BYTES   = 24;
	localparam int SCREEN_ROWS = 64;
	localparam int PLANES      = 2;
	localparam int SCREEN_COLS = ROW_BYTES * 8;
	localparam int PLANE_BYTES = ROW_BYTES * SCREEN_ROWS;
	localparam int STORE_BYTES = PLANE_BYTES * PLANES;
	localparam int RANDOM_CMDS = 2000;
	// Longest quiet tail: a clear sweeps the whole store.
	localparam int TAIL_CYCLES = STORE_BYTES + 1000;

	// Command codes with no meaning and raster ops out of range.
	localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
	localparam logic [2:0] OP_BAD_LO     = 3'd5;
	localparam logic [2:0] OP_BAD_HI     = 3'd7;

	typedef struct {
		logic [2:0] cmd;
		logic [7:0] xs;
		logic [7:0] ys;
		logic [7:0] xe;
		logic [7:0] ye;
		logic [1:0] color;
		logic [2:0] op;
		bit         fixed;     // expected colour typed into the table
		logic [1:0] fixed_color;
	} draw_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;

	logic [7:0] shadow_fb [STORE_BYTES];
	logic [1:0] pending_colors [$];
	draw_cmd_t  directed_rows [$];
	int         errors;
	bit         quiet;             // stretch with no idling on either side

	bitplane_raster_draw_engine_unit #(
		.ROW_BYTES(ROW_BYTES), .SCREEN_ROWS(SCREEN_ROWS), .PLANES(PLANES)
	) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit.
	initial begin
		#100000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Frame store model: one pixel with a raster op in every plane.
	function automatic void plot(int x, int y, logic [1:0] color, logic [2:0] op);
		int idx;
		logic [7:0] mask;
		logic c;
		if (x < 0 || x >= SCREEN_COLS || y < 0 || y >= SCREEN_ROWS || op > OP_XOR)
			return;
		mask = LEFT_BIT >> (x % 8);
		for (int p = 0; p < PLANES; p++) begin
			idx = p * PLANE_BYTES + y * ROW_BYTES + x / 8;
			c = (p < 2) ? color[p] : 1'b0;
			case (op)
				OP_SET: shadow_fb[idx] = c ? (shadow_fb[idx] | mask) : (shadow_fb[idx] & ~mask);
				OP_OR:  if (c) shadow_fb[idx] = shadow_fb[idx] | mask;
				OP_INV: shadow_fb[idx] = c ? (shadow_fb[idx] & ~mask) : (shadow_fb[idx] | mask);
				OP_AND: if (!c) shadow_fb[idx] = shadow_fb[idx] & ~mask;
				default: if (c) shadow_fb[idx] = shadow_fb[idx] ^ mask;
			endcase
		end
	endfunction

	function automatic logic [1:0] sample_pixel(int x, int y);
		logic [1:0] c;
		c = 2'b00;
		if (x >= SCREEN_COLS || y >= SCREEN_ROWS)
			return c;
		for (int p = 0; p < PLANES && p < 2; p++)
			if (shadow_fb[p * PLANE_BYTES + y * ROW_BYTES + x / 8] & (LEFT_BIT >> (x % 8)))
				c[p] = 1'b1;
		return c;
	endfunction

	// Bresenham line in set mode, same walk order and tie rule as the block.
	function automatic void trace_line(int x0, int y0, int x1, int y1, logic [1:0] color);
		int dx, dy, step, t, cx, cy, err;
		bit steep;
		dx = x1 - x0;
		dy = y1 - y0;
		step = 1;
		steep = 1'b0;
		if (dx < 0) begin
			dx = -dx; dy = -dy;
			t = x0; x0 = x1; x1 = t;
			t = y0; y0 = y1; y1 = t;
		end
		if (dy == 0) begin
			for (cx = x0; cx <= x1; cx++) plot(cx, y0, color, OP_SET);
			return;
		end
		if (dx == 0) begin
			if (y0 > y1) begin t = y0; y0 = y1; y1 = t; end
			for (cy = y0; cy <= y1; cy++) plot(x0, cy, color, OP_SET);
			return;
		end
		if (dy < 0) begin step = -1; dy = -dy; end
		if (dy > dx) begin
			steep = 1'b1;
			t = dx; dx = dy; dy = t;
			t = x0; x0 = y0; y0 = t;
			t = x1; x1 = y1; y1 = t;
		end
		if (x0 > x1) begin
			t = x0; x0 = x1; x1 = t;
			t = y0; y0 = y1; y1 = t;
		end
		cx = x0; cy = y0; err = -dx;
		while (cx <= x1) begin
			if (steep) plot(cy, cx, color, OP_SET);
			else plot(cx, cy, color, OP_SET);
			cx++;
			err += 2 * dy;
			if (err > 0) begin
				cy += step;
				err -= 2 * dx;
			end
		end
	endfunction

	// Applies one accepted command to the model and queues any read colour.
	function automatic void draw_model(draw_cmd_t d);
		int a, b;
		case (d.cmd)
			CMD_SET: plot(d.xs, d.ys, d.color, OP_SET);
			CMD_READ: pending_colors.push_back(d.fixed ? d.fixed_color : sample_pixel(d.xs, d.ys));
			CMD_HSPAN: begin
				a = (d.xs < d.xe) ? d.xs : d.xe;
				b = (d.xs < d.xe) ? d.xe : d.xs;
				for (int i = a; i <= b; i++) plot(i, d.ys, d.color, d.op);
			end
			CMD_VSPAN: begin
				a = (d.ys < d.ye) ? d.ys : d.ye;
				b = (d.ys < d.ye) ? d.ye : d.ys;
				for (int i = a; i <= b; i++) plot(d.xs, i, d.color, d.op);
			end
			CMD_LINE: trace_line(d.xs, d.ys, d.xe, d.ye, d.color);
			CMD_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
			default: ;
		endcase
	endfunction

	function automatic draw_cmd_t mk(logic [2:0] cmd, logic [7:0] xs, logic [7:0] ys,
			logic [7:0] xe, logic [7:0] ye, logic [1:0] color, logic [2:0] op,
			bit fixed = 1'b0, logic [1:0] fixed_color = 2'b00);
		draw_cmd_t d;
		d.cmd = cmd; d.xs = xs; d.ys = ys; d.xe = xe; d.ye = ye;
		d.color = color; d.op = op; d.fixed = fixed; d.fixed_color = fixed_color;
		return d;
	endfunction

	// Random command, mostly short and near the top-left corner so reads hit ink.
	function automatic draw_cmd_t random_cmd();
		draw_cmd_t d;
		int sel, xmax, ymax, reach;
		sel = $urandom_range(0, 99);
		if (sel < 30) d.cmd = CMD_READ;
		else if (sel < 45) d.cmd = CMD_SET;
		else if (sel < 65) d.cmd = CMD_HSPAN;
		else if (sel < 80) d.cmd = CMD_VSPAN;
		else if (sel < 96) d.cmd = CMD_LINE;
		else if (sel < 97) d.cmd = CMD_CLEAR;
		else d.cmd = $urandom_range(0, 1) ? CMD_UNUSED_LO : CMD_UNUSED_HI;
		sel = $urandom_range(0, 99);
		xmax = (sel < 60) ? 47 : (sel < 92) ? SCREEN_COLS + 7 : 255;
		ymax = (sel < 60) ? 15 : (sel < 92) ? SCREEN_ROWS + 3 : 255;
		reach = ($urandom_range(0, 19) == 0) ? 255 : 12;
		d.xs = 8'($urandom_range(0, xmax));
		d.ys = 8'($urandom_range(0, ymax));
		d.xe = (reach == 255) ? 8'($urandom_range(0, 255))
			: 8'(int'(d.xs) + $urandom_range(0, 2 * reach) - reach);
		d.ye = (reach == 255) ? 8'($urandom_range(0, 255))
			: 8'(int'(d.ys) + $urandom_range(0, 2 * reach) - reach);
		d.color = 2'($urandom_range(0, 3));
		d.op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(OP_BAD_LO, OP_BAD_HI))
			: 3'($urandom_range(OP_SET, OP_XOR));
		d.fixed = 1'b0;
		d.fixed_color = 2'b00;
		return d;
	endfunction

	// Drives one command and waits for its transaction.
	task automatic send_cmd(draw_cmd_t d);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= {d.op, d.color, d.ye, d.xe, d.ys, d.xs, d.cmd};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		draw_model(d);
	endtask

	// Result side: a random stall before each result is taken.
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Compare every result transaction with the oldest expected colour.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_colors.size() == 0) begin
				$display("%0t unexpected result: expected none actual %0d", $time,
					m_axis_tdata[1:0]);
				errors++;
			end else begin
				logic [1:0] want;
				want = pending_colors.pop_front();
				if (m_axis_tdata[1:0] !== want) begin
					$display("%0t pixel_color mismatch: expected %0d actual %0d", $time,
						want, m_axis_tdata[1:0]);
					errors++;
				end
			end
		end
	end

	// Main sequence.
	initial begin
		errors = 0;
		quiet = 1'b0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;

		// Directed table.
		directed_rows.push_back(mk(CMD_READ, 0, 0, 0, 0, 0, OP_SET, 1, 2'd0));
		directed_rows.push_back(mk(CMD_SET, 0, 0, 0, 0, 3, OP_BAD_HI));
		directed_rows.push_back(mk(CMD_READ, 0, 0, 0, 0, 0, OP_SET, 1, 2'd3));
		directed_rows.push_back(mk(CMD_SET, 191, 63, 0, 0, 2, OP_SET));
		directed_rows.push_back(mk(CMD_READ, 191, 63, 0, 0, 0, OP_SET, 1, 2'd2));
		directed_rows.push_back(mk(CMD_SET, 255, 255, 0, 0, 3, OP_SET));
		directed_rows.push_back(mk(CMD_READ, 255, 255, 0, 0, 0, OP_SET, 1, 2'd0));
		directed_rows.push_back(mk(CMD_READ, 192, 0, 0, 0, 0, OP_SET, 1, 2'd0));
		directed_rows.push_back(mk(CMD_HSPAN, 20, 3, 4, 0, 1, OP_SET));
		directed_rows.push_back(mk(CMD_HSPAN, 8, 3, 16, 0, 2, OP_OR));
		directed_rows.push_back(mk(CMD_HSPAN, 10, 3, 12, 0, 1, OP_INV));
		directed_rows.push_back(mk(CMD_HSPAN, 4, 3, 20, 0, 2, OP_AND));
		directed_rows.push_back(mk(CMD_HSPAN, 180, 3, 255, 0, 3, OP_XOR));
		directed_rows.push_back(mk(CMD_HSPAN, 0, 3, 30, 0, 3, OP_BAD_LO));
		directed_rows.push_back(mk(CMD_VSPAN, 5, 70, 50, 0, 3, OP_SET));
		directed_rows.push_back(mk(CMD_VSPAN, 5, 55, 60, 255, 1, OP_XOR));
		directed_rows.push_back(mk(CMD_READ, 12, 3, 0, 0, 0, OP_SET));
		directed_rows.push_back(mk(CMD_READ, 5, 58, 0, 0, 0, OP_SET));
		directed_rows.push_back(mk(CMD_LINE, 0, 0, 40, 13, 2, OP_INV));
		directed_rows.push_back(mk(CMD_LINE, 30, 2, 25, 30, 1, OP_SET));
		directed_rows.push_back(mk(CMD_LINE, 100, 60, 180, 60, 3, OP_SET));
		directed_rows.push_back(mk(CMD_READ, 20, 6, 0, 0, 0, OP_SET));
		directed_rows.push_back(mk(CMD_UNUSED_LO, 1, 1, 1, 1, 3, OP_SET));
		directed_rows.push_back(mk(CMD_UNUSED_HI, 1, 1, 1, 1, 3, OP_SET));
		directed_rows.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 0, OP_SET));
		directed_rows.push_back(mk(CMD_READ, 0, 0, 0, 0, 0, OP_SET, 1, 2'd0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) send_cmd(directed_rows[i]);
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			// Toggle stretches with no idling every so often.
			if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
			send_cmd(random_cmd());
		end
		s_axis_tvalid <= 1'b0;

		while (pending_colors.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire

@@ bitplane_raster_draw_engine_unit.f @@
+incdir+design
design/brd_pkg.sv
design/brd_datapath.sv
design/brd_ctrl.sv
design/bitplane_raster_draw_engine_unit.sv
tb/tb.sv
